FILE: rtl/dq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the deque.
`default_nettype none

package dq_pkg;

    // Ring size and the widths that follow from it
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed payload widths
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the incoming transaction
        logic exec;    // update ring, indices and count
        logic load;    // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
`default_nettype none

// A bounded deque of DEPTH (16) signed words kept in a ring with front and back
// indices and a count. Each input transaction carries a command (push back,
// push front, pop back, pop front) and a push word; each yields exactly one
// result transaction with the popped word (zero unless a pop succeeded), the
// occupancy after the command, and a status: done, pop on empty refused, or
// push on full refused. A refused command changes nothing. Each transaction
// passes through the steps accept, execute and load result, and no new one
// is taken until the last is loaded; the load step waits for the one-entry
// output register, and the entry RAM's registered read port sets the
// execute-to-load split. The next transaction is accepted while a finished
// result still waits in the output register. Entries are not cleared at
// reset; a pop only ever reads entries that an earlier push wrote.
module double_ended_queue (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [dq_pkg::CMD_W-1:0]         i_command,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_push_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [dq_pkg::DATA_W-1:0]      o_pop_value,
    output logic [dq_pkg::OCC_W-1:0]              o_occupancy,
    output logic [dq_pkg::STAT_W-1:0]             o_status
);
    import dq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: one transaction in flight at a time
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Ring storage, indices, count and output register
    dq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pop_value  (o_pop_value),
        .o_occupancy  (o_occupancy),
        .o_status     (o_status)
    );

    // A refused pop always reports an empty deque
    a_pop_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_POP_EMPTY) |-> (o_occupancy == '0))
        else $error("pop refusal with non-zero occupancy");

    // A refused push always reports a full deque
    a_push_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_PUSH_FULL) |-> (o_occupancy == OCC_W'(DEPTH)))
        else $error("push refusal with occupancy below depth");

    // A refused command never returns a word
    a_refused_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_pop_value == '0))
        else $error("refused command returned a word");

endmodule

`default_nettype wire

FILE: rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/dq_datapath.sv
// Deque datapath: command register, ring indices, count, entry RAM and result register.
`default_nettype none

module dq_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dq_pkg::t_dp_cmd              i_cmd,
    output dq_pkg::t_dp_stat                  o_stat,
    input  wire logic [dq_pkg::CMD_W-1:0]     i_command,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [dq_pkg::DATA_W-1:0]  o_pop_value,
    output logic [dq_pkg::OCC_W-1:0]          o_occupancy,
    output logic [dq_pkg::STAT_W-1:0]         o_status
);
    import dq_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Captured transaction
    logic [CMD_W-1:0]  r_cmd;
    logic [DATA_W-1:0] r_value;

    // Ring state
    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;

    // Per-item outcome held until the result is loaded
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_pop_ok;

    // Output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_pop;
    logic [OCC_W-1:0]         r_out_occ;
    logic [STAT_W-1:0]        r_out_status;

    logic              is_push, full, empty, push_ok, pop_ok;
    logic [IDX_W-1:0]  front_prev, front_next, back_prev, back_next;
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign is_push = (r_cmd == CMD_PUSH_BACK) || (r_cmd == CMD_PUSH_FRONT);
    assign full    = (r_count == CNT_FULL);
    assign empty   = (r_count == '0);
    assign push_ok = is_push && !full;
    assign pop_ok  = !is_push && !empty;

    assign front_prev = (r_front == '0)      ? IDX_LAST : r_front - 1'b1;
    assign front_next = (r_front == IDX_LAST) ? '0      : r_front + 1'b1;
    assign back_prev  = (r_back  == '0)      ? IDX_LAST : r_back - 1'b1;
    assign back_next  = (r_back  == IDX_LAST) ? '0      : r_back + 1'b1;

    assign wr_en   = i_cmd.exec && push_ok;
    assign wr_addr = (r_cmd == CMD_PUSH_BACK) ? r_back : front_prev;
    assign rd_en   = i_cmd.exec && pop_ok;
    assign rd_addr = (r_cmd == CMD_POP_BACK) ? back_prev : r_front;

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = ST_DONE;
        case (r_cmd)
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_back  = back_next;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    n_front = front_prev;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_back  = back_prev;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_front = front_next;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Transaction capture, outcome and output data registers carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= i_command;
            r_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= pop_ok;
        end
        if (i_cmd.load) begin
            r_out_pop    <= r_pop_ok ? $signed(rd_data) : '0;
            r_out_occ    <= OCC_W'(r_count);
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_out_pop;
    assign o_occupancy = r_out_occ;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

FILE: rtl/dq_ctrl.sv
// Deque controller: sequences accept, execute and result load for one transaction.
`default_nettype none

module dq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire dq_pkg::t_dp_stat i_stat,
    output dq_pkg::t_dp_cmd       o_cmd
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.latch = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register has room
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: test/dq_result_checker.sv
// Predicts and checks the result transactions of the double-ended queue.
`timescale 1ns / 1ps

module dq_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [dq_pkg::CMD_W-1:0]         i_command,
    input  logic signed [dq_pkg::DATA_W-1:0] i_push_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [dq_pkg::DATA_W-1:0] i_pop_value,
    input  logic [dq_pkg::OCC_W-1:0]         i_occupancy,
    input  logic [dq_pkg::STAT_W-1:0]        i_status,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_pop_empty_seen,
    output int                               o_push_full_seen,
    output int                               o_full_seen
);
    import dq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [OCC_W-1:0]         occupancy;
        logic [STAT_W-1:0]        status;
    } t_deque_result;

    // Shadow copy of the ring
    logic [DATA_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]  head_slot;
    logic [IDX_W-1:0]  tail_slot;
    logic [CNT_W-1:0]  held_words;

    t_deque_result expected_results [$];
    int            fails          = 0;
    int            checked        = 0;
    int            pop_empty_seen = 0;
    int            push_full_seen = 0;
    int            full_seen      = 0;

    // Apply one command to the shadow ring and return what the block should report
    function automatic t_deque_result step_deque(input logic [CMD_W-1:0] cmd,
                                                 input logic [DATA_W-1:0] word);
        t_deque_result res;
        res.pop_value = '0;
        res.status    = ST_DONE;
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) begin
            if (held_words >= DEPTH) begin
                res.status = ST_PUSH_FULL;
            end else if (cmd == CMD_PUSH_BACK) begin
                ring_words[tail_slot] = word;
                tail_slot  = tail_slot + 1'b1;
                held_words = held_words + 1'b1;
            end else begin
                head_slot  = head_slot - 1'b1;
                ring_words[head_slot] = word;
                held_words = held_words + 1'b1;
            end
        end else begin
            if (held_words == 0) begin
                res.status = ST_POP_EMPTY;
            end else if (cmd == CMD_POP_BACK) begin
                tail_slot     = tail_slot - 1'b1;
                res.pop_value = ring_words[tail_slot];
                held_words    = held_words - 1'b1;
            end else begin
                res.pop_value = ring_words[head_slot];
                head_slot     = head_slot + 1'b1;
                held_words    = held_words - 1'b1;
            end
        end
        res.occupancy = OCC_W'(held_words);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result got;
        if (!i_rst_n) begin
            head_slot  = '0;
            tail_slot  = '0;
            held_words = '0;
            expected_results.delete();
        end else begin
            // Check the outgoing transaction first: it can never stem from this edge's input
            if (i_out_valid && !i_out_stall) begin
                got.pop_value = i_pop_value;
                got.occupancy = i_occupancy;
                got.status    = i_status;
                if (expected_results.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("ERROR: unexpected result pop=%0d occ=%0d status=%0d",
                                 got.pop_value, got.occupancy, got.status);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    checked = checked + 1;
                    if (want.status == ST_POP_EMPTY) pop_empty_seen = pop_empty_seen + 1;
                    if (want.status == ST_PUSH_FULL) push_full_seen = push_full_seen + 1;
                    if (want.occupancy == DEPTH)     full_seen = full_seen + 1;
                    if (got.pop_value !== want.pop_value || got.occupancy !== want.occupancy ||
                        got.status !== want.status) begin
                        fails = fails + 1;
                        if (fails <= 10)
                            $display("ERROR: result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     checked, want.pop_value, want.occupancy, want.status,
                                     got.pop_value, got.occupancy, got.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results = {expected_results, step_deque(i_command, i_push_value)};
        end
        o_fail_count     <= fails;
        o_pending        <= expected_results.size();
        o_checked        <= checked;
        o_pop_empty_seen <= pop_empty_seen;
        o_push_full_seen <= push_full_seen;
        o_full_seen      <= full_seen;
    end

endmodule

FILE: test/tb_double_ended_queue.sv
// Testbench top for the double-ended queue: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_double_ended_queue;
    import dq_pkg::*;

    // Cycles in which neither channel moves a transaction before the run is declared hung
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int PAUSE_EVERY   = 300;
    localparam int TAIL_CYCLES   = 12;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command = CMD_PUSH_BACK;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_pop_value;
    logic [OCC_W-1:0]         o_occupancy;
    logic [STAT_W-1:0]        o_status;

    int fail_count;
    int pending;
    int checked;
    int pop_empty_seen;
    int push_full_seen;
    int full_seen;

    int commands_sent = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    int stall_left    = 0;
    int stall_mode    = 0;

    always #4 i_clk = ~i_clk;

    double_ended_queue u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pop_value  (o_pop_value),
        .o_occupancy  (o_occupancy),
        .o_status     (o_status)
    );

    dq_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_push_value     (i_push_value),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_pop_value      (o_pop_value),
        .i_occupancy      (o_occupancy),
        .i_status         (o_status),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_pop_empty_seen (pop_empty_seen),
        .o_push_full_seen (push_full_seen),
        .o_full_seen      (full_seen)
    );

    // Offer one command transaction, hold it until accepted, then apply the burst/gap pattern.
    // Valid is only lowered once the burst runs out, so back-to-back transactions keep it high.
    task automatic drive_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
        int gap;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        commands_sent = commands_sent + 1;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // Now and then run a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(0, 20);
        end else begin
            burst_left = burst_left - 1;
        end
    endtask

    // Drop valid and hold off until every outstanding result has been returned
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Push word: mostly fully random, sometimes one of the extreme values
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stall on a random pattern, picking a new mode whenever the mode counter runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 30);
            2:       i_out_stall <= ($urandom_range(0, 99) < 85);
            default: i_out_stall <= stall_left[2];
        endcase
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int random_sent;
        int next_pause;
        int push_pct;
        int phase_len;
        logic [CMD_W-1:0] cmd;

        random_sent = 0;
        next_pause  = PAUSE_EVERY;

        // Hold reset low, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: pops on an empty deque from both ends
        drive_command(CMD_POP_BACK, 32'h1234_5678);
        drive_command(CMD_POP_FRONT, 32'hFFFF_FFFF);
        // Extreme words from both ends, then pop one from each end
        drive_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        drive_command(CMD_PUSH_FRONT, 32'h8000_0000);
        drive_command(CMD_PUSH_BACK, 32'h0000_0000);
        drive_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        drive_command(CMD_POP_FRONT, 32'h0);
        drive_command(CMD_POP_BACK, 32'h0);
        // Fill to the brim from alternating ends
        for (int k = 0; k < DEPTH - 2; k++)
            drive_command(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
        // Pushes on a full deque are refused at either end
        drive_command(CMD_PUSH_BACK, 32'h5A5A_5A5A);
        drive_command(CMD_PUSH_FRONT, 32'hA5A5_A5A5);

        wait_for_drain();

        // Random part: phases biased towards filling, draining or churning
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 85;
                1:       push_pct = 15;
                2:       push_pct = 50;
                default: push_pct = 65;
            endcase
            phase_len = $urandom_range(4, 40);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < push_pct)
                    cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                drive_command(cmd, pick_word());
                random_sent = random_sent + 1;
            end
            if (random_sent >= next_pause) begin
                wait_for_drain();
                next_pause = next_pause + PAUSE_EVERY;
            end
        end

        // Let the last results come home, then let the clock run idle before the verdict
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d results; %0d refused pops, %0d refused pushes,",
                 commands_sent, checked, pop_empty_seen, push_full_seen);
        $display("and %0d results that reported a full deque.", full_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
